/* hw/rtl/mdio_frm_pkg.sv */
// Shared types and constants for the Clause 22 MDIO management frame master.
// Used by the frame engine and by the top level; depends on nothing else.
package mdio_frm_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int DATA_BITS     = 16;
  localparam int ADDR_BITS     = 5;
  localparam int TAIL_BITS     = 32;
  localparam int FRAME_BITS    = PREAMBLE_BITS + TAIL_BITS;
  localparam int CNT_W         = $clog2(FRAME_BITS);

  localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(FRAME_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_PRE      = CNT_W'(PREAMBLE_BITS);
  localparam logic [CNT_W-1:0] CNT_HDR_END  = CNT_W'(PREAMBLE_BITS + 14);
  localparam logic [CNT_W-1:0] CNT_RD_FIRST = CNT_W'(PREAMBLE_BITS + 15);
  localparam logic [CNT_W-1:0] CNT_RD_END   = CNT_W'(PREAMBLE_BITS + 15 + DATA_BITS);

  localparam logic [1:0] SOF_CODE      = 2'b01;
  localparam logic [1:0] OP_READ       = 2'b10;
  localparam logic [1:0] OP_WRITE      = 2'b01;
  localparam logic [1:0] TA_WRITE      = 2'b10;
  localparam logic [1:0] TA_READ       = 2'b00;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } mdio_action_t;

  typedef struct packed {
    logic                 mdio_out;
    logic                 mdio_drive;
    logic                 busy;
    logic                 done;
    logic [DATA_BITS-1:0] read_data;
  } mdio_res_t;

endpackage

/* hw/rtl/mdio_frm_engine.sv */
// Frame engine: holds the frame state and works out one bit period per request.
// Depends on mdio_frm_pkg.
module mdio_frm_engine
  import mdio_frm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [1:0]           action,
  input  logic [ADDR_BITS-1:0] phy_addr,
  input  logic [ADDR_BITS-1:0] reg_addr,
  input  logic [DATA_BITS-1:0] write_data,
  input  logic                 mdio_in,
  output mdio_res_t            res
);

  logic [TAIL_BITS-1:0] frame_shift_r, frame_shift_nxt;
  logic [CNT_W-1:0]     bit_count_r, bit_count_nxt;
  logic                 is_write_r, is_write_nxt;
  logic                 in_progress_r, in_progress_nxt;
  logic [DATA_BITS-1:0] read_shift_r, read_shift_nxt;

  logic                 start;
  logic                 active;
  logic                 cur_write;
  logic [TAIL_BITS-1:0] cur_shift;
  logic [CNT_W-1:0]     cur_count;
  logic [DATA_BITS-1:0] cur_rshift;
  logic [TAIL_BITS-1:0] start_word;

  always_comb begin
    start = !in_progress_r &&
            (action == ACT_READ || action == ACT_WRITE);
    if (action == ACT_WRITE) begin
      start_word = {SOF_CODE, OP_WRITE, phy_addr, reg_addr, TA_WRITE, write_data};
    end else begin
      start_word = {SOF_CODE, OP_READ, phy_addr, reg_addr, TA_READ, {DATA_BITS{1'b0}}};
    end
    active     = in_progress_r || start;
    cur_write  = start ? (action == ACT_WRITE) : is_write_r;
    cur_shift  = start ? start_word : frame_shift_r;
    cur_count  = start ? '0 : bit_count_r;
    cur_rshift = start ? '0 : read_shift_r;

    frame_shift_nxt = cur_shift;
    read_shift_nxt  = cur_rshift;
    is_write_nxt    = cur_write;
    in_progress_nxt = active;
    bit_count_nxt   = cur_count;
    res             = '0;

    if (active) begin
      res.busy = 1'b1;
      if (cur_count < CNT_PRE) begin
        res.mdio_drive = 1'b1;
        res.mdio_out   = 1'b1;
      end else if (cur_write || cur_count < CNT_HDR_END) begin
        res.mdio_drive  = 1'b1;
        res.mdio_out    = cur_shift[TAIL_BITS-1];
        frame_shift_nxt = {cur_shift[TAIL_BITS-2:0], 1'b0};
      end else if (cur_count >= CNT_RD_FIRST && cur_count < CNT_RD_END) begin
        read_shift_nxt = {cur_rshift[DATA_BITS-2:0], mdio_in};
      end
      if (cur_count >= CNT_LAST) begin
        res.done        = 1'b1;
        in_progress_nxt = 1'b0;
        bit_count_nxt   = '0;
        res.read_data   = cur_write ? '0 : cur_rshift;
      end else begin
        bit_count_nxt = cur_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r <= '0;
      bit_count_r   <= '0;
      is_write_r    <= 1'b0;
      in_progress_r <= 1'b0;
      read_shift_r  <= '0;
    end else if (step_en) begin
      frame_shift_r <= frame_shift_nxt;
      bit_count_r   <= bit_count_nxt;
      is_write_r    <= is_write_nxt;
      in_progress_r <= in_progress_nxt;
      read_shift_r  <= read_shift_nxt;
    end
  end

  a_idle_count_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !in_progress_r |-> bit_count_r == '0)
    else $error("bit counter left nonzero while idle");

  a_busy_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    in_progress_r |-> bit_count_r != '0)
    else $error("frame in progress with counter at its first period");

endmodule

/* hw/rtl/mdio_frm_out_stage.sv */
// Result register stage: holds one finished bit period until the receiver takes it.
// Depends on mdio_frm_pkg.
module mdio_frm_out_stage
  import mdio_frm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  mdio_res_t res_in,
  input  logic      out_stall,
  output logic      out_valid,
  output logic      can_load,
  output mdio_res_t res_out
);

  logic      vld_r;
  mdio_res_t res_r;

  assign can_load  = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (can_load) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res_in;
    end
  end

  a_done_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && res_r.done |-> res_r.busy)
    else $error("frame end reported outside a frame");

  a_out_only_driven : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && res_r.mdio_out |-> res_r.mdio_drive && res_r.busy)
    else $error("line value set while released");

  a_rdata_at_done : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && res_r.read_data != '0 |-> res_r.done)
    else $error("read word shown before the last period");

endmodule

/* hw/rtl/mdio_management_frame_master_core.sv */
// Top level of the Clause 22 MDIO management frame master.
// Depends on mdio_frm_pkg, mdio_frm_engine and mdio_frm_out_stage.
//
// Each request on the in_ channel is one MDC bit period. A request with
// in_action read or write while no frame runs starts a 64-period frame
// (preamble, start, opcode, PHY and register address, then turnaround and
// data); start requests during a frame count as plain ticks. Every request
// yields exactly one result on the out_ channel: the line value and drive
// enable for that period, busy and done flags, and the read word on the
// last period of a read frame.
// A request is held in an input register, then processed by the frame
// engine and written to the result register. One request is taken per
// cycle while the result register is not held by out_stall.
// When the receiver asserts out_stall, the result register holds and the
// input register fills; in_stall then rises until the result is taken.
// Reset clears the frame state and both valid flags; the block is idle
// with the line released.
module mdio_management_frame_master_core
  import mdio_frm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_phy_addr,
  input  logic [ADDR_BITS-1:0] in_reg_addr,
  input  logic [DATA_BITS-1:0] in_write_data,
  input  logic                 in_mdio_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_mdio_out,
  output logic                 out_mdio_drive,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [DATA_BITS-1:0] out_read_data
);

  logic                 in_vld_r;
  logic [1:0]           action_r;
  logic [ADDR_BITS-1:0] phy_addr_r;
  logic [ADDR_BITS-1:0] reg_addr_r;
  logic [DATA_BITS-1:0] write_data_r;
  logic                 mdio_in_r;

  logic      can_load;
  logic      step_en;
  logic      in_take;
  mdio_res_t eng_res;
  mdio_res_t out_res;

  assign step_en  = in_vld_r && can_load;
  assign in_stall = in_vld_r && !can_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r     <= in_action;
      phy_addr_r   <= in_phy_addr;
      reg_addr_r   <= in_reg_addr;
      write_data_r <= in_write_data;
      mdio_in_r    <= in_mdio_in;
    end
  end

  mdio_frm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .action     (action_r),
    .phy_addr   (phy_addr_r),
    .reg_addr   (reg_addr_r),
    .write_data (write_data_r),
    .mdio_in    (mdio_in_r),
    .res        (eng_res)
  );

  mdio_frm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_vld_r),
    .res_in    (eng_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_out   (out_res)
  );

  assign out_mdio_out   = out_res.mdio_out;
  assign out_mdio_drive = out_res.mdio_drive;
  assign out_busy_res   = out_res.busy;
  assign out_done_res   = out_res.done;
  assign out_read_data  = out_res.read_data;

endmodule

/* bench/tb_mdio_management_frame_master_core.sv */
// Self-checking testbench for the Clause 22 MDIO management frame master.
// Drives MDC bit-period requests, predicts every result period and checks it.
// Depends on mdio_frm_pkg and mdio_management_frame_master_core.
module tb_mdio_management_frame_master_core;
  import mdio_frm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_REQS = 450;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [1:0]           action;
    logic [ADDR_BITS-1:0] phy;
    logic [ADDR_BITS-1:0] regn;
    logic [DATA_BITS-1:0] wdata;
    logic                 line;
  } mdio_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_action = ACT_TICK;
  logic [ADDR_BITS-1:0] in_phy_addr = '0;
  logic [ADDR_BITS-1:0] in_reg_addr = '0;
  logic [DATA_BITS-1:0] in_write_data = '0;
  logic                 in_mdio_in = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_mdio_out;
  logic                 out_mdio_drive;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [DATA_BITS-1:0] out_read_data;

  mdio_req_t pending_reqs[$];
  mdio_res_t expected_periods[$];
  mdio_req_t cur_req;

  // Predicted frame state.
  logic [31:0]          hdr_word = '0;
  logic [6:0]           bit_idx = '0;
  logic                 wr_frame = 1'b0;
  logic                 frame_on = 1'b0;
  logic [DATA_BITS-1:0] rd_word = '0;

  int err_count = 0;
  int accepted_reqs = 0;
  int checked_periods = 0;
  int read_frames = 0;
  int write_frames = 0;
  int cycles = 0;
  int in_gap = 0;
  int stall_left = 0;

  mdio_management_frame_master_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_phy_addr    (in_phy_addr),
    .in_reg_addr    (in_reg_addr),
    .in_write_data  (in_write_data),
    .in_mdio_in     (in_mdio_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mdio_out   (out_mdio_out),
    .out_mdio_drive (out_mdio_drive),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_read_data  (out_read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mdio_res_t predict_period(mdio_req_t rq);
    mdio_res_t  r;
    logic [6:0] h;
    r = '0;
    if (!frame_on && (rq.action == ACT_READ || rq.action == ACT_WRITE)) begin
      wr_frame = (rq.action == ACT_WRITE);
      hdr_word = {SOF_CODE, wr_frame ? OP_WRITE : OP_READ, rq.phy, rq.regn,
                  wr_frame ? TA_WRITE : TA_READ, wr_frame ? rq.wdata : 16'h0000};
      bit_idx = '0;
      rd_word = '0;
      frame_on = 1'b1;
      if (wr_frame) write_frames++;
      else read_frames++;
    end
    if (frame_on) begin
      r.busy = 1'b1;
      if (bit_idx < PREAMBLE_BITS) begin
        r.mdio_drive = 1'b1;
        r.mdio_out = 1'b1;
      end else begin
        h = bit_idx - 7'(PREAMBLE_BITS);
        if (wr_frame || h < 14) begin
          r.mdio_drive = 1'b1;
          r.mdio_out = hdr_word[31];
          hdr_word = hdr_word << 1;
        end else if (h >= 15 && h < 15 + DATA_BITS) begin
          rd_word = {rd_word[DATA_BITS-2:0], rq.line};
        end
      end
      if (bit_idx >= FRAME_BITS - 1) begin
        r.done = 1'b1;
        r.read_data = wr_frame ? '0 : rd_word;
        frame_on = 1'b0;
        bit_idx = '0;
      end else begin
        bit_idx = bit_idx + 7'd1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] want,
                                 input logic [DATA_BITS-1:0] got);
    $display("MISMATCH at period %0d, %s: expected %0h, got %0h",
             checked_periods, what, want, got);
    err_count++;
  endtask

  task automatic push_req(input logic [1:0] act, input logic [ADDR_BITS-1:0] phy,
                          input logic [ADDR_BITS-1:0] regn,
                          input logic [DATA_BITS-1:0] wdata, input logic line);
    mdio_req_t rq;
    rq.action = act;
    rq.phy = phy;
    rq.regn = regn;
    rq.wdata = wdata;
    rq.line = line;
    pending_reqs.push_back(rq);
  endtask

  // One whole frame: the start request, then the remaining bit periods with
  // random content. Line mode 0 samples random levels, 1 all ones, 2 all zeros.
  task automatic add_frame(input logic [1:0] start_act, input logic [ADDR_BITS-1:0] phy,
                           input logic [ADDR_BITS-1:0] regn,
                           input logic [DATA_BITS-1:0] wdata, input int line_mode,
                           input bit busy_starts);
    int         k;
    logic [1:0] act;
    logic       ln;
    push_req(start_act, phy, regn, wdata, line_mode == 1);
    for (k = 1; k < FRAME_BITS; k++) begin
      case ($urandom_range(0, 11))
        0: act = ACT_READ;
        1: act = ACT_WRITE;
        2: act = ACT_UNUSED;
        default: act = ACT_TICK;
      endcase
      if (busy_starts && k == 1) act = ACT_WRITE;
      if (busy_starts && k == FRAME_BITS - 1) act = ACT_READ;
      ln = (line_mode == 0) ? 1'($urandom) : (line_mode == 1);
      push_req(act, 5'($urandom), 5'($urandom), 16'($urandom), ln);
    end
  endtask

  function automatic bit winding_down();
    return pending_reqs.size() < 80;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_periods.push_back(predict_period(cur_req));
        accepted_reqs++;
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!winding_down() && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_req.action;
          in_phy_addr <= cur_req.phy;
          in_reg_addr <= cur_req.regn;
          in_write_data <= cur_req.wdata;
          in_mdio_in <= cur_req.line;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mdio_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_periods.size() == 0) begin
          report_mismatch("result with no request pending", '0, '0);
        end else begin
          want = expected_periods.pop_front();
          if (out_mdio_out !== want.mdio_out)
            report_mismatch("mdio_out", 16'(want.mdio_out), 16'(out_mdio_out));
          if (out_mdio_drive !== want.mdio_drive)
            report_mismatch("mdio_drive", 16'(want.mdio_drive), 16'(out_mdio_drive));
          if (out_busy_res !== want.busy)
            report_mismatch("busy_res", 16'(want.busy), 16'(out_busy_res));
          if (out_done_res !== want.done)
            report_mismatch("done_res", 16'(want.done), 16'(out_done_res));
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, out_read_data);
        end
        checked_periods++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!winding_down() && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_periods.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int k;
    // Idle periods with extreme field values, including the unused action code.
    push_req(ACT_TICK, '0, '0, '0, 1'b0);
    push_req(ACT_UNUSED, '1, '1, '1, 1'b1);
    push_req(ACT_TICK, '1, '1, '1, 1'b1);
    push_req(ACT_UNUSED, '0, '0, '0, 1'b0);
    // A write with all-ones fields and start requests during the frame, then a
    // read right behind it that samples an all-ones line.
    add_frame(ACT_WRITE, '1, '1, '1, 0, 1'b1);
    add_frame(ACT_READ, '0, '0, '0, 1, 1'b0);
    add_frame(ACT_READ, '1, '0, '1, 2, 1'b1);
    while (pending_reqs.size() < TARGET_REQS) begin
      if ($urandom_range(0, 4) != 0) begin
        add_frame($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 5'($urandom),
                  5'($urandom), 16'($urandom), 0, 1'($urandom_range(0, 3) == 0));
      end else begin
        for (k = $urandom_range(1, 5); k > 0; k--)
          push_req($urandom_range(0, 1) ? ACT_UNUSED : ACT_TICK, 5'($urandom),
                   5'($urandom), 16'($urandom), 1'($urandom));
      end
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_periods.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d bit periods: %0d read and %0d write frames, %0d results checked.",
             accepted_reqs, read_frames, write_frames, checked_periods);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
